>>> rtl/iprbm_pkg.sv
// Shared types and constants for the IPv4 rule blacklist matcher.
// Used by iprbm_cell and ip_rule_blacklist_matcher; no dependencies.
package iprbm_pkg;

   localparam int unsigned NUM_LISTS_DEFAULT   = 32;
   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_ADD   = 2'd1,
      OP_TICK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Request as held by the top level and broadcast to every cell.
   typedef struct packed {
      op_type      opcode;
      logic [4:0]  list_id;
      logic [31:0] address;
      logic [31:0] net_mask;
      logic [15:0] port;
      logic [3:0]  proto;
      logic        invert;
      logic [31:0] now;
      logic [31:0] list_select;
      logic [31:0] expiring;
      logic [31:0] expiry;
   } req_type;

   // Token handed from cell to cell, one hop per cycle.
   typedef struct packed {
      logic active;   // token present
      logic commit;   // 0: scan pass, 1: store pass
      logic store;    // store pass: rule not yet placed
      logic hit;      // scan: match (check) or duplicate (add) seen
      logic free;     // scan: an empty cell seen
   } token_type;

endpackage

>>> rtl/iprbm_cell.sv
// One rule cell of the matcher chain: holds a rule, acts on the passing token.
// Depends on iprbm_pkg.
module iprbm_cell (
   input  logic                clock,
   input  logic                reset,
   input  iprbm_pkg::req_type   req,
   input  iprbm_pkg::token_type token_in,
   output iprbm_pkg::token_type token_out
);
   import iprbm_pkg::*;

   logic        valid_ff, valid_in;
   logic [4:0]  list_ff;
   logic [31:0] address_ff;
   logic [31:0] mask_ff;
   logic [15:0] port_ff;
   logic [3:0]  proto_ff;
   logic        invert_ff;
   logic [31:0] expiry_ff;
   token_type   token_ff, token_in_d;

   logic scan, capture, rule_hit, rule_applies, dup, check_hit, expire, clear_hit;

   always_comb begin
      scan    = token_in.active && !token_in.commit;
      capture = token_in.active && token_in.commit && token_in.store && !valid_ff;

      rule_hit = (port_ff == 16'd0 || port_ff == req.port)
              && (proto_ff == 4'd0 || proto_ff == req.proto)
              && ((req.address & mask_ff) == (address_ff & mask_ff));
      rule_applies = rule_hit ^ invert_ff;

      dup = valid_ff && list_ff == req.list_id && invert_ff == req.invert
         && port_ff == req.port && proto_ff == req.proto
         && (address_ff & mask_ff) == (req.address & req.net_mask);

      check_hit = valid_ff && req.list_select[list_ff] && rule_applies;
      expire    = valid_ff && req.expiring[list_ff] && expiry_ff <= req.now;
      clear_hit = valid_ff && list_ff == req.list_id;

      valid_in = valid_ff;
      if (capture) begin
         valid_in = 1'b1;
      end else if (scan && req.opcode == OP_TICK && expire) begin
         valid_in = 1'b0;
      end else if (scan && req.opcode == OP_CLEAR && clear_hit) begin
         valid_in = 1'b0;
      end

      token_in_d       = token_in;
      token_in_d.store = token_in.store && !capture;
      token_in_d.hit   = token_in.hit
                      || (scan && req.opcode == OP_CHECK && check_hit)
                      || (scan && req.opcode == OP_ADD && dup);
      token_in_d.free  = token_in.free || (scan && !valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         token_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         token_ff <= token_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         list_ff    <= req.list_id;
         address_ff <= req.address;
         mask_ff    <= req.net_mask;
         port_ff    <= req.port;
         proto_ff   <= req.proto;
         invert_ff  <= req.invert;
         expiry_ff  <= req.expiry;
      end
   end

   assign token_out = token_ff;

endmodule

>>> rtl/ip_rule_blacklist_matcher.sv
// Top level of the IPv4 rule blacklist matcher: request/result control, APB
// registers and the chain of rule cells. Depends on iprbm_pkg and iprbm_cell.
//
//   channel  | ports                        | handshake
//   request  | start, busy, req_*           | taken when start && !busy
//   result   | rsp_strobe, rsp_*            | one-cycle strobe, never stalled
//   config   | psel, penable, pwrite, paddr | APB read/write, pready tied high
//
// A token walks the cell chain, one cell per cycle; the next request is
// taken only after the token leaves the last cell. An add that stores a
// rule walks the chain a second time after its result, and busy stays high
// until that pass ends. Reset clears every rule valid bit at once. Results
// cannot be held off; busy stalls the request side while a pass runs.
module ip_rule_blacklist_matcher #(
   parameter int unsigned NUM_LISTS   = iprbm_pkg::NUM_LISTS_DEFAULT,
   parameter int unsigned TABLE_DEPTH = iprbm_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_list_id,
   input  logic [31:0] req_address,
   input  logic [31:0] req_net_mask,
   input  logic [15:0] req_port,
   input  logic [3:0]  req_proto,
   input  logic        req_invert,
   input  logic [31:0] req_now,
   input  logic [31:0] req_list_select,
   output logic        rsp_strobe,
   output logic        rsp_matched,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import iprbm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_type;

   state_type   state_ff, state_in;
   req_type     req_ff;
   token_type   launch_ff, launch_in;
   logic        rsp_strobe_ff, rsp_matched_ff;
   logic        rsp_strobe_in, rsp_matched_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] expiring_lists_ff, rule_lifetime_ff;

   token_type              tok [TABLE_DEPTH];
   token_type              last_tok;
   logic [TABLE_DEPTH-1:0] tok_active;

   logic accept, cfg_write, list_in_range, add_ok;

   assign accept        = start && state_ff == ST_IDLE;
   assign cfg_write     = psel && penable && pwrite;
   assign busy          = state_ff != ST_IDLE;
   assign pready        = 1'b1;
   assign prdata        = paddr[2] ? rule_lifetime_ff : expiring_lists_ff;
   assign last_tok      = tok[TABLE_DEPTH-1];
   assign list_in_range = {1'b0, req_ff.list_id} < 6'(NUM_LISTS);
   assign add_ok        = list_in_range && !last_tok.hit && last_tok.free;

   always_ff @(posedge clock) begin
      if (reset) begin
         expiring_lists_ff <= '0;
         rule_lifetime_ff  <= 32'd1;
      end else if (cfg_write) begin
         if (paddr[2]) begin
            rule_lifetime_ff <= pwdata;
         end else begin
            expiring_lists_ff <= pwdata;
         end
      end
   end

   // request capture; held steady while the chain works on it
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.opcode      <= op_type'(req_opcode);
         req_ff.list_id     <= req_list_id;
         req_ff.address     <= req_address;
         req_ff.net_mask    <= req_net_mask;
         req_ff.port        <= req_port;
         req_ff.proto       <= req_proto;
         req_ff.invert      <= req_invert;
         req_ff.now         <= req_now;
         req_ff.list_select <= req_list_select;
         req_ff.expiring    <= expiring_lists_ff;
         req_ff.expiry      <= expiring_lists_ff[req_list_id]
                               ? req_now + rule_lifetime_ff : 32'd0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      launch_in      = '0;
      rsp_strobe_in  = 1'b0;
      rsp_matched_in = rsp_matched_ff;
      rsp_status_in  = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               launch_in.active = 1'b1;
               state_in         = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_tok.active) begin
               rsp_strobe_in  = 1'b1;
               rsp_matched_in = req_ff.opcode == OP_CHECK && last_tok.hit;
               rsp_status_in  = STATUS_OK;
               state_in       = ST_IDLE;
               if (req_ff.opcode == OP_ADD && list_in_range) begin
                  if (last_tok.hit) begin
                     rsp_status_in = STATUS_DUP;
                  end else if (!last_tok.free) begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               if (req_ff.opcode == OP_ADD && add_ok) begin
                  launch_in.active = 1'b1;
                  launch_in.commit = 1'b1;
                  launch_in.store  = 1'b1;
                  state_in         = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (last_tok.active) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         launch_ff      <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_matched_ff <= 1'b0;
         rsp_status_ff  <= STATUS_OK;
      end else begin
         state_ff       <= state_in;
         launch_ff      <= launch_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_matched_ff <= rsp_matched_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_matched = rsp_matched_ff;
   assign rsp_status  = rsp_status_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         iprbm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .req       (req_ff),
            .token_in  (launch_ff),
            .token_out (tok[i])
         );
      end else begin : g_body
         iprbm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .req       (req_ff),
            .token_in  (tok[i-1]),
            .token_out (tok[i])
         );
      end
      assign tok_active[i] = tok[i].active;
   end

   // only one token may be in flight
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones({launch_ff.active, tok_active}) <= 1)
      else $error("more than one token in the cell chain");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (launch_ff.active || tok_active != '0) |-> busy)
      else $error("token in flight while idle");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_SCAN)
      else $error("result strobe without a finished scan pass");

   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_matched |-> rsp_status == STATUS_OK)
      else $error("match reported with a nonzero status");

   a_commit_scan: assert property (@(posedge clock) disable iff (reset)
      launch_ff.active && launch_ff.commit |-> $past(state_ff) == ST_SCAN)
      else $error("store pass launched outside a scan pass");

endmodule
